// File: design/alarm_table_minute_matcher_macros.svh
// Assertion macros shared by the alarm table design.
`ifndef ALARM_TABLE_MINUTE_MATCHER_MACROS_SVH
`define ALARM_TABLE_MINUTE_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AATMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AATMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/aatmm_pkg.sv
// Types, codes and helpers for the alarm table minute matcher.
`timescale 1ns / 1ps

package aatmm_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 2;
    localparam int WINDOW_W    = 6;
    localparam int MOD_W       = 11;   // minute of day, up to 31*60+63
    localparam int RCNT_W      = 5;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_UPDATE = 3'd3;
    localparam logic [2:0] CMD_TOGGLE = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;
    localparam logic [2:0] CMD_MISSED = 3'd6;

    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_FIRE   = 2'd1;
    localparam logic [1:0] KIND_MISSED = 2'd2;

    localparam logic       ST_OK     = 1'b0;
    localparam logic       ST_REJECT = 1'b1;

    localparam logic [4:0]        HOUR_TOP      = 5'd23;
    localparam logic [5:0]        MINUTE_TOP    = 6'd59;
    localparam logic [MOD_W-1:0]  MIN_PER_HOUR  = 11'd60;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd5;
    localparam logic [RCNT_W-1:0] RESULT_LIMIT  = 5'd16;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enabled;
        logic       recurring;
        logic [6:0] mask;
    } entry_t;

    typedef struct packed {
        logic shift;    // take the neighbor's entry
        logic write;    // take the write data
        logic toggle;   // flip the enabled bit
    } cell_ctrl_t;

    function automatic logic [MOD_W-1:0] mins_of_day(input logic [4:0] h,
                                                     input logic [5:0] m);
        mins_of_day = MOD_W'(h) * MIN_PER_HOUR + MOD_W'(m);
    endfunction

endpackage

// File: design/alarm_table_minute_matcher.sv
// Alarm table minute matcher: top level, command decode and output stage.
// Add, remove, update, toggle, clear, bad code: answer registered in the next cycle.
// Tick that is ignored (nonzero second or repeated minute): no beat.
// Tick and missed check that scan: one full rotation of the cell chain past the single
// match unit at its head, then a flush state; output stalls hold the scan.
// rst_n (async, active low) clears count, last-fire marker, window (to 5) and control.
`timescale 1ns / 1ps
`include "alarm_table_minute_matcher_macros.svh"

module alarm_table_minute_matcher #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command beat in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // hour[4:0] minute[10:5] second[16:11] weekday[19:17] slot_index[23:20]
    // recurring[24] day_mask[31:25] enable[32], zero pad above
    input  logic [aatmm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command[2:0]
    input  logic [aatmm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result beat out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[0] entry[4:1] enabled_now[5], zero pad above
    output logic [aatmm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // kind[1:0]
    output logic [aatmm_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                                m_axis_tlast,
    // missed window register
    input  logic                                cfg_wr_en,
    input  logic [aatmm_pkg::WINDOW_W-1:0]      cfg_wr_data
);
    import aatmm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // input fields
    logic [2:0] in_cmd;
    logic [4:0] in_hour;
    logic [5:0] in_minute;
    logic [5:0] in_second;
    logic [2:0] in_weekday;
    logic [3:0] in_slot;
    logic       in_rec;
    logic [6:0] in_mask;
    logic       in_enable;

    assign in_cmd     = s_axis_tuser;
    assign in_hour    = s_axis_tdata[4:0];
    assign in_minute  = s_axis_tdata[10:5];
    assign in_second  = s_axis_tdata[16:11];
    assign in_weekday = s_axis_tdata[19:17];
    assign in_slot    = s_axis_tdata[23:20];
    assign in_rec     = s_axis_tdata[24];
    assign in_mask    = s_axis_tdata[31:25];
    assign in_enable  = s_axis_tdata[32];

    // control state
    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       scan_i_reg, scan_i_next;
    logic [RCNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                lf_valid_reg, lf_valid_next;
    logic [4:0]          lf_hour_reg, lf_hour_next;
    logic [5:0]          lf_minute_reg, lf_minute_next;
    logic [WINDOW_W-1:0] window_reg;

    // scan operands, latched at command accept
    logic                sc_missed_reg, sc_missed_next;
    logic [4:0]          sc_hour_reg, sc_hour_next;
    logic [5:0]          sc_minute_reg, sc_minute_next;
    logic [2:0]          sc_weekday_reg, sc_weekday_next;
    logic [MOD_W-1:0]    sc_now_reg, sc_now_next;

    // pending fired result, held until the next hit or the end of the scan
    logic [1:0]          pend_kind_reg, pend_kind_next;
    logic [3:0]          pend_entry_reg, pend_entry_next;
    logic                pend_en_reg, pend_en_next;

    // output stage payload
    logic [1:0]          out_kind_reg, out_kind_next;
    logic                out_status_reg, out_status_next;
    logic [3:0]          out_entry_reg, out_entry_next;
    logic                out_en_reg, out_en_next;
    logic                out_last_reg, out_last_next;

    // handshake and decode
    logic                accept;
    logic                out_free;
    logic                step;
    logic                i_valid;
    logic [XW-1:0]       idx_x;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       tgt_x;
    logic [CW+3:0]       i_ext;
    logic [CW+3:0]       cnt_ext;
    logic                bad_time;
    logic                bad_idx;
    logic                add_reject;
    logic                wr_do;
    logic                rm_do;
    logic                tog_do;
    logic                en_cur;
    entry_t              wr_data;

    // chain
    entry_t              cell_q   [MAX_ENTRIES];
    entry_t              cell_nbr [MAX_ENTRIES];
    cell_ctrl_t          cell_ctl [MAX_ENTRIES];
    logic                m_hit;
    entry_t              m_head_mod;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign step          = (state_reg == ST_SCAN) && out_free;
    assign i_valid       = scan_i_reg < cnt_reg;

    assign idx_x      = XW'(in_slot);
    assign cnt_x      = XW'(cnt_reg);
    assign i_ext      = {4'b0000, scan_i_reg};
    assign cnt_ext    = {4'b0000, cnt_reg};
    assign bad_time   = (in_hour > HOUR_TOP) || (in_minute > MINUTE_TOP);
    assign bad_idx    = idx_x >= cnt_x;
    assign add_reject = (cnt_reg >= CW'(MAX_ENTRIES)) || bad_time;

    // add writes at the fill count, update at the addressed slot
    assign tgt_x = (in_cmd == CMD_ADD) ? cnt_x : idx_x;

    assign wr_do  = accept && (((in_cmd == CMD_ADD) && !add_reject) ||
                               ((in_cmd == CMD_UPDATE) && !bad_idx && !bad_time));
    assign rm_do  = accept && (in_cmd == CMD_REMOVE) && !bad_idx;
    assign tog_do = accept && (in_cmd == CMD_TOGGLE) && !bad_idx;

    always_comb
    begin
        wr_data.hour      = in_hour;
        wr_data.minute    = in_minute;
        wr_data.enabled   = (in_cmd == CMD_ADD) ? 1'b1 : in_enable;
        wr_data.recurring = in_rec;
        wr_data.mask      = in_mask;
    end

    // enabled bit of the addressed slot, for the toggle answer
    always_comb
    begin
        en_cur = 1'b0;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            if (XW'(k) == idx_x)
            begin
                en_cur = cell_q[k].enabled;
            end
        end
    end

    // Cell chain. During a scan every cell takes its upper neighbor each step and
    // the top cell takes the head after matching, so the table rotates once and
    // entry i sits in cell 0 at step i. Remove shifts the cells at and above the
    // slot down by one.
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        if (k == MAX_ENTRIES - 1)
        begin : g_top
            assign cell_nbr[k] = m_head_mod;
        end
        else
        begin : g_mid
            assign cell_nbr[k] = cell_q[k + 1];
        end

        assign cell_ctl[k].shift  = step || (rm_do && (XW'(k) >= idx_x));
        assign cell_ctl[k].write  = wr_do && (XW'(k) == tgt_x);
        assign cell_ctl[k].toggle = tog_do && (XW'(k) == idx_x);

        aatmm_cell u_cell (
            .clk   (clk),
            .ctrl  (cell_ctl[k]),
            .nbr   (cell_nbr[k]),
            .wdata (wr_data),
            .q     (cell_q[k])
        );
    end

    aatmm_match u_match (
        .active   (i_valid),
        .missed   (sc_missed_reg),
        .head     (cell_q[0]),
        .hour     (sc_hour_reg),
        .minute   (sc_minute_reg),
        .weekday  (sc_weekday_reg),
        .now      (sc_now_reg),
        .window   (window_reg),
        .hit      (m_hit),
        .head_mod (m_head_mod)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_i_next     = scan_i_reg;
        rep_cnt_next    = rep_cnt_reg;
        pend_valid_next = pend_valid_reg;
        lf_valid_next   = lf_valid_reg;
        lf_hour_next    = lf_hour_reg;
        lf_minute_next  = lf_minute_reg;
        sc_missed_next  = sc_missed_reg;
        sc_hour_next    = sc_hour_reg;
        sc_minute_next  = sc_minute_reg;
        sc_weekday_next = sc_weekday_reg;
        sc_now_next     = sc_now_reg;
        pend_kind_next  = pend_kind_reg;
        pend_entry_next = pend_entry_reg;
        pend_en_next    = pend_en_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_en_next     = out_en_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default: one answer beat, rejected
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_ANSWER;
                    out_status_next = ST_REJECT;
                    out_entry_next  = 4'd0;
                    out_en_next     = 1'b0;
                    out_last_next   = 1'b1;

                    sc_hour_next    = in_hour;
                    sc_minute_next  = in_minute;
                    sc_weekday_next = in_weekday;
                    sc_now_next     = mins_of_day(in_hour, in_minute);
                    scan_i_next     = '0;
                    rep_cnt_next    = '0;
                    pend_valid_next = 1'b0;

                    unique case (in_cmd)
                        CMD_TICK:
                        begin
                            out_valid_next = 1'b0;
                            // second zero, once per hour and minute
                            if ((in_second == 6'd0) &&
                                !(lf_valid_reg && (lf_hour_reg == in_hour) &&
                                  (lf_minute_reg == in_minute)))
                            begin
                                lf_valid_next  = 1'b1;
                                lf_hour_next   = in_hour;
                                lf_minute_next = in_minute;
                                sc_missed_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (!add_reject)
                            begin
                                out_status_next = ST_OK;
                                out_entry_next  = cnt_ext[3:0];
                                cnt_next        = cnt_reg + CW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!bad_idx)
                            begin
                                out_status_next = ST_OK;
                                cnt_next        = cnt_reg - CW'(1);
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (!bad_idx && !bad_time)
                            begin
                                out_status_next = ST_OK;
                            end
                        end
                        CMD_TOGGLE:
                        begin
                            if (!bad_idx)
                            begin
                                out_status_next = ST_OK;
                                out_en_next     = !en_cur;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            out_status_next = ST_OK;
                            cnt_next        = '0;
                        end
                        CMD_MISSED:
                        begin
                            out_valid_next = 1'b0;
                            sc_missed_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            // unused code: rejected answer already set up
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (i_valid && m_hit && (rep_cnt_reg < RESULT_LIMIT))
                    begin
                        // a new hit releases the previous one, not last
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = pend_kind_reg;
                            out_status_next = ST_OK;
                            out_entry_next  = pend_entry_reg;
                            out_en_next     = pend_en_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = sc_missed_reg ? KIND_MISSED : KIND_FIRE;
                        pend_entry_next = i_ext[3:0];
                        pend_en_next    = m_head_mod.enabled;
                        rep_cnt_next    = rep_cnt_reg + RCNT_W'(1);
                    end
                    if (scan_i_reg == CW'(MAX_ENTRIES - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        scan_i_next = scan_i_reg + CW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = pend_kind_reg;
                        out_status_next = ST_OK;
                        out_entry_next  = pend_entry_reg;
                        out_en_next     = pend_en_reg;
                        out_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            scan_i_reg     <= '0;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            lf_valid_reg   <= 1'b0;
            lf_hour_reg    <= '0;
            lf_minute_reg  <= '0;
            window_reg     <= WINDOW_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            scan_i_reg     <= scan_i_next;
            rep_cnt_reg    <= rep_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            lf_valid_reg   <= lf_valid_next;
            lf_hour_reg    <= lf_hour_next;
            lf_minute_reg  <= lf_minute_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        sc_missed_reg  <= sc_missed_next;
        sc_hour_reg    <= sc_hour_next;
        sc_minute_reg  <= sc_minute_next;
        sc_weekday_reg <= sc_weekday_next;
        sc_now_reg     <= sc_now_next;
        pend_kind_reg  <= pend_kind_next;
        pend_entry_reg <= pend_entry_next;
        pend_en_reg    <= pend_en_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_en_reg     <= out_en_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_en_reg, out_entry_reg, out_status_reg};

    `AATMM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_ENTRIES), "entry count above table size")
    `AATMM_ASSERT_IMP(a_idle_no_pend, state_reg == ST_IDLE, !pend_valid_reg, "pending result left when idle")
    `AATMM_ASSERT_IMP(a_rep_bound, 1'b1, rep_cnt_reg <= RESULT_LIMIT, "reported results above limit")
    `AATMM_ASSERT_NEXT(a_add_grows, accept && (in_cmd == CMD_ADD) && !add_reject, cnt_reg == $past(cnt_reg) + CW'(1), "accepted add did not grow the table")

endmodule

// File: design/aatmm_cell.sv
// One alarm entry cell of the table chain.
`timescale 1ns / 1ps

module aatmm_cell (
    input  logic                  clk,
    input  aatmm_pkg::cell_ctrl_t ctrl,
    input  aatmm_pkg::entry_t     nbr,
    input  aatmm_pkg::entry_t     wdata,
    output aatmm_pkg::entry_t     q
);
    import aatmm_pkg::*;

    entry_t entry_reg;

    // payload only, no reset: contents are defined once written
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= nbr;
        end
        else if (ctrl.write)
        begin
            entry_reg <= wdata;
        end
        else if (ctrl.toggle)
        begin
            entry_reg.enabled <= ~entry_reg.enabled;
        end
    end

    assign q = entry_reg;

endmodule

// File: design/aatmm_match.sv
// Match logic at the head of the chain: day, time and window checks.
`timescale 1ns / 1ps

module aatmm_match (
    input  logic                           active,
    input  logic                           missed,
    input  aatmm_pkg::entry_t              head,
    input  logic [4:0]                     hour,
    input  logic [5:0]                     minute,
    input  logic [2:0]                     weekday,
    input  logic [aatmm_pkg::MOD_W-1:0]    now,
    input  logic [aatmm_pkg::WINDOW_W-1:0] window,
    output logic                           hit,
    output aatmm_pkg::entry_t              head_mod
);
    import aatmm_pkg::*;

    logic [7:0]       mask_ext;
    logic             day_ok;
    logic [MOD_W-1:0] at_mod;
    logic [MOD_W-1:0] gap_min;
    logic             tick_hit;
    logic             missed_hit;

    // weekday 7 lands on the padded zero bit
    assign mask_ext   = {1'b0, head.mask};
    assign day_ok     = !head.recurring || (head.mask == 7'd0) || mask_ext[weekday];

    assign at_mod     = mins_of_day(head.hour, head.minute);
    assign gap_min    = now - at_mod;
    assign missed_hit = (now > at_mod) && (gap_min <= MOD_W'(window));
    assign tick_hit   = (head.hour == hour) && (head.minute == minute);

    assign hit = active && head.enabled && day_ok && (missed ? missed_hit : tick_hit);

    always_comb
    begin
        head_mod = head;
        if (hit && !head.recurring)
        begin
            head_mod.enabled = 1'b0;
        end
    end

endmodule
